FILE: rtl/upe_pkg.sv
// Shared types, constants and character classification functions for the URL percent encoder.
package upe_pkg;

    localparam int SAFE_W          = 18;
    localparam int CFG_IDX_W       = 1;
    localparam int SLOTS           = 8;
    localparam int SLOT_CNT_W      = 4;
    localparam int SLOT_IDX_W      = 3;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_ESCAPES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFE_MASK    = 1'b1;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_TWO     = 8'h32;
    localparam logic [7:0] CH_FIVE    = 8'h35;

    // "%25", first byte in the low bits
    localparam logic [23:0] ESC_PERCENT = {CH_FIVE, CH_TWO, CH_PERCENT};

    // : / ? # [ ] @ ! $ & ' ( ) * + , ; =
    localparam logic [7:0] RESERVED_CHARS [SAFE_W] = '{
        8'h3A, 8'h2F, 8'h3F, 8'h23, 8'h5B, 8'h5D, 8'h40, 8'h21, 8'h24,
        8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D
    };

    localparam logic [7:0] HEX_UPPER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    // One classified input byte: the output bytes it causes, first byte in the low bits
    typedef struct packed {
        logic [SLOTS*8-1:0]    bytes;
        logic [SLOT_CNT_W-1:0] count;
        logic                  last;
    } cmd_t;

    // Head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

    function automatic logic is_hex(input logic [7:0] b);
        return b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic passes(input logic [7:0] b, input logic [SAFE_W-1:0] mask);
        logic hit;
        hit = b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                        8'h2E, 8'h7E, 8'h5F, 8'h2D};
        for (int i = 0; i < SAFE_W; i++) begin
            if (b == RESERVED_CHARS[i] && mask[i])
                hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return HEX_UPPER[nib];
    endfunction

endpackage

FILE: rtl/upe_front.sv
// Front end: configuration registers, escape lookahead and expansion of each byte into a command.
module upe_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [upe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [upe_pkg::SAFE_W-1:0]   cfg_data,
    input  logic                         take,
    input  logic [7:0]                   data_byte,
    input  logic                         message_last,
    output logic                         cmd_push,
    output upe_pkg::cmd_t                cmd
);
    import upe_pkg::*;

    logic              keep_reg;
    logic [SAFE_W-1:0] safe_mask_reg;
    logic [1:0]        held_count_reg;
    logic [1:0]        held_count_next;
    logic [7:0]        held_digit_reg;
    logic [7:0]        held_digit_next;

    logic [31:0] p_bytes;
    logic [23:0] e_bytes;
    logic [31:0] f_bytes;
    logic [2:0]  len_p;
    logic [1:0]  len_e;
    logic [2:0]  len_f;
    logic [2:0]  off_f;
    logic [1:0]  hc_mid;
    logic        consumed;
    logic        b_hex;

    always_comb
    begin
        b_hex           = is_hex(data_byte);
        p_bytes         = '0;
        e_bytes         = '0;
        f_bytes         = '0;
        len_p           = 3'd0;
        len_e           = 2'd0;
        len_f           = 3'd0;
        consumed        = 1'b0;
        hc_mid          = 2'd0;
        held_digit_next = held_digit_reg;

        // resolve what is already held
        case (held_count_reg)
            2'd0:
            begin
                hc_mid = 2'd0;
            end
            2'd1:
            begin
                if (keep_reg && b_hex)
                begin
                    held_digit_next = data_byte;
                    hc_mid          = 2'd2;
                    consumed        = 1'b1;
                end
                else
                begin
                    p_bytes = {8'h00, ESC_PERCENT};
                    len_p   = 3'd3;
                end
            end
            default:
            begin
                if (keep_reg && b_hex)
                begin
                    p_bytes  = {8'h00, data_byte, held_digit_reg, CH_PERCENT};
                    len_p    = 3'd3;
                    consumed = 1'b1;
                end
                else
                begin
                    p_bytes = {held_digit_reg, ESC_PERCENT};
                    len_p   = 3'd4;
                end
            end
        endcase

        if (!consumed)
        begin
            if (keep_reg && data_byte == CH_PERCENT)
                hc_mid = 2'd1;
            else if (passes(data_byte, safe_mask_reg))
            begin
                e_bytes = {16'h0000, data_byte};
                len_e   = 2'd1;
            end
            else
            begin
                e_bytes = {hex_char(data_byte[3:0]), hex_char(data_byte[7:4]), CH_PERCENT};
                len_e   = 2'd3;
            end
        end

        // flush at message end
        held_count_next = hc_mid;
        if (message_last && hc_mid != 2'd0)
        begin
            held_count_next = 2'd0;
            if (hc_mid == 2'd1)
            begin
                f_bytes = {8'h00, ESC_PERCENT};
                len_f   = 3'd3;
            end
            else
            begin
                f_bytes = {held_digit_next, ESC_PERCENT};
                len_f   = 3'd4;
            end
        end

        off_f = len_p + {1'b0, len_e};
        cmd.bytes = {32'h0, p_bytes}
                  | ({40'h0, e_bytes} << {len_p, 3'b000})
                  | ({32'h0, f_bytes} << {off_f, 3'b000});
        cmd.count = {1'b0, off_f} + {1'b0, len_f};
        cmd.last  = message_last;
        cmd_push  = take && (cmd.count != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg       <= 1'b0;
            safe_mask_reg  <= '0;
            held_count_reg <= 2'd0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_KEEP_ESCAPES)
                keep_reg <= cfg_data[0];
            if (cfg_we && cfg_index == CFG_SAFE_MASK)
                safe_mask_reg <= cfg_data;
            if (take)
                held_count_reg <= held_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            held_digit_reg <= held_digit_next;
    end

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg != 2'd3)
        else $error("held count out of range");

    a_cmd_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> cmd.count <= SLOT_CNT_W'(SLOTS - 1))
        else $error("command longer than seven bytes");

    a_hold_silent: assert property (@(posedge clk) disable iff (!rst_n)
        take && message_last |=> held_count_reg == 2'd0)
        else $error("bytes still held after message end");

endmodule

FILE: rtl/upe_queue.sv
// Command queue between the front end and the back end.
module upe_queue #(
    parameter int DEPTH = upe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  upe_pkg::cmd_t  wr_cmd,
    output logic           full,
    input  logic           rd_en,
    output upe_pkg::head_t head
);
    import upe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    cmd_t             entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;

    assign full       = (level_reg == LVL_W'(DEPTH));
    assign head.valid = (level_reg != '0);
    assign head.cmd   = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        level_next = level_reg + LVL_W'(wr_en) - LVL_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entries[wr_ptr_reg] <= wr_cmd;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full || rd_en)
        else $error("write into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> head.valid)
        else $error("read from an empty queue");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_W'(DEPTH))
        else $error("queue level out of range");

endmodule

FILE: rtl/upe_back.sv
// Back end: serializes the head command into one output byte per transfer.
module upe_back (
    input  logic           clk,
    input  logic           rst_n,
    input  upe_pkg::head_t head,
    output logic           deq,
    output logic           empty,
    input  logic           pop,
    output logic [7:0]     out_byte,
    output logic           run_last,
    output logic           message_done
);
    import upe_pkg::*;

    logic [SLOT_IDX_W-1:0] idx_reg;
    logic [SLOT_IDX_W-1:0] idx_next;
    logic                  take;
    logic                  last_slot;

    assign empty        = !head.valid;
    assign take         = pop && head.valid;
    assign last_slot    = ({1'b0, idx_reg} + 1'b1) == head.cmd.count;
    assign out_byte     = head.cmd.bytes[{idx_reg, 3'b000} +: 8];
    assign run_last     = last_slot;
    assign message_done = last_slot && head.cmd.last;
    assign deq          = take && last_slot;

    always_comb
    begin
        idx_next = idx_reg;
        if (deq)
            idx_next = '0;
        else if (take)
            idx_next = idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

    a_idx_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        head.valid |-> {1'b0, idx_reg} < head.cmd.count)
        else $error("slot index past command length");

    a_idx_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        deq |=> idx_reg == '0)
        else $error("slot index not rewound after command");

endmodule

FILE: rtl/url_percent_encoder_core.sv
// Top level of the streaming URL percent encoder.
//
//  channel   direction  handshake           payload
//  input     in         push / full         data_byte, message_last
//  result    out        empty / pop         out_byte, run_last, message_done
//  config    in         cfg_we              cfg_index, cfg_data
//
// An input byte is classified in the cycle it is taken and becomes 0 to 7 output bytes.
// The back end sends one output byte per cycle while pop is held, so a byte needing %XX leaves as three output bytes.
// Up to QUEUE_DEPTH expanded input bytes wait between front and back; full rises when it fills.
// Reset clears the held-escape count, the queue and the configuration registers.
// A stall on pop holds the current result steady; input keeps flowing until the queue fills.
module url_percent_encoder_core #(
    parameter int QUEUE_DEPTH = upe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [upe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [upe_pkg::SAFE_W-1:0]    cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    data_byte,
    input  logic                          message_last,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    out_byte,
    output logic                          run_last,
    output logic                          message_done
);
    import upe_pkg::*;

    logic  take;
    logic  cmd_push;
    logic  deq;
    cmd_t  cmd;
    head_t head;

    assign take = push && !full;

    upe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .take         (take),
        .data_byte    (data_byte),
        .message_last (message_last),
        .cmd_push     (cmd_push),
        .cmd          (cmd)
    );

    upe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_cmd (cmd),
        .full   (full),
        .rd_en  (deq),
        .head   (head)
    );

    upe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .deq          (deq),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .message_done (message_done)
    );

endmodule

FILE: tb/sv/tb_url_percent_encoder_core.sv
// Self-checking testbench for url_percent_encoder_core: directed table, then random messages.
module tb_url_percent_encoder_core;
    import upe_pkg::*;

    localparam int SETTLE_CYCLES  = 30;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 46;
    localparam int NUM_PHASES     = 8;

    // first character in the high bits
    localparam logic [SAFE_W*8-1:0] RESERVED = ":/?#[]@!$&'()*+,;=";
    localparam logic [22*8-1:0]     HEX_POOL = "0123456789ABCDEFabcdef";

    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e         kind;
        logic [SAFE_W-1:0] value;  // data byte, or safe mask for a config row
        logic              keep;
        logic              last;
        logic              typed;
        logic [3:0]        n;
        logic [63:0]       chars;  // typed result, first byte in the high bits
    } row_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       message_done;
    } result_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = CFG_KEEP_ESCAPES;
    logic [SAFE_W-1:0]    cfg_data     = '0;
    logic                 push         = 1'b0;
    logic                 full;
    logic [7:0]           data_byte    = 8'h00;
    logic                 message_last = 1'b0;
    logic                 empty;
    logic                 pop          = 1'b0;
    logic [7:0]           out_byte;
    logic                 run_last;
    logic                 message_done;

    url_percent_encoder_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .message_last (message_last),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .message_done (message_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // encoder state as predicted
    logic              esc_keep   = 1'b0;
    logic [SAFE_W-1:0] safe_bits  = '0;
    int                held_n     = 0;
    logic [7:0]        held_digit = 8'h00;

    logic [7:0] step_out [$];   // bytes caused by the current input byte
    result_t    encoded_q [$];  // encoded bytes still to come out
    logic [7:0] msg_q [$];
    row_t       dir_rows [$];

    int   fail_cnt     = 0;
    int   items_sent   = 0;
    int   stall_cycles = 0;
    logic tx_idle      = 1'b1;
    logic rx_idle      = 1'b1;
    logic rx_hold_req  = 1'b0;

    function automatic void add_step(input logic [7:0] b);
        step_out.insert(step_out.size(), b);
    endfunction

    function automatic void add_msg(input logic [7:0] b);
        msg_q.insert(msg_q.size(), b);
    endfunction

    function automatic void add_result(input result_t r);
        encoded_q.insert(encoded_q.size(), r);
    endfunction

    function automatic logic hex_digit(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
    endfunction

    function automatic logic [7:0] hex_of(input logic [3:0] v);
        return (v < 4'd10) ? 8'h30 + {4'h0, v} : 8'h37 + {4'h0, v};
    endfunction

    function automatic logic passes_raw(input logic [7:0] b);
        logic hit;
        hit = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9") ||
              b == "." || b == "~" || b == "_" || b == "-";
        for (int i = 0; i < SAFE_W; i++)
            if (RESERVED[(SAFE_W-1-i)*8 +: 8] == b)
                hit = safe_bits[i];
        return hit;
    endfunction

    function automatic void emit_enc(input logic [7:0] b);
        if (passes_raw(b))
            add_step(b);
        else
        begin
            add_step("%");
            add_step(hex_of(b[7:4]));
            add_step(hex_of(b[3:0]));
        end
    endfunction

    function automatic void flush_held();
        if (held_n >= 1)
            emit_enc("%");
        if (held_n >= 2)
            add_step(held_digit);
        held_n = 0;
    endfunction

    // bytes that one accepted input byte causes, into step_out
    function automatic void encode_byte(input logic [7:0] b, input logic last);
        logic consumed;
        consumed = 1'b0;
        step_out.delete();
        if (held_n == 1)
        begin
            if (esc_keep && hex_digit(b))
            begin
                held_digit = b;
                held_n     = 2;
                consumed   = 1'b1;
            end
            else
                flush_held();
        end
        else if (held_n >= 2)
        begin
            if (esc_keep && hex_digit(b))
            begin
                // complete escape goes through as is
                add_step("%");
                add_step(held_digit);
                add_step(b);
                held_n   = 0;
                consumed = 1'b1;
            end
            else
                flush_held();
        end
        if (!consumed)
        begin
            if (esc_keep && b == "%")
                held_n = 1;
            else
                emit_enc(b);
        end
        if (last && held_n > 0)
            flush_held();
    endfunction

    function automatic row_t byte_row(input logic [7:0] b, input logic last);
        row_t r;
        r       = '0;
        r.kind  = ROW_BYTE;
        r.value = {10'h0, b};
        r.last  = last;
        return r;
    endfunction

    function automatic row_t known_row(input logic [7:0] b, input logic last,
                                       input logic [3:0] n, input logic [63:0] chars);
        row_t r;
        r       = byte_row(b, last);
        r.typed = 1'b1;
        r.n     = n;
        r.chars = chars;
        return r;
    endfunction

    function automatic row_t cfg_row(input logic keep, input logic [SAFE_W-1:0] mask);
        row_t r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.keep  = keep;
        r.value = mask;
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input logic [3:0] n, input logic [63:0] chars);
        int unsigned gap;
        result_t     r;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        data_byte    <= b;
        message_last <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        encode_byte(b, last);
        if (typed)
        begin
            step_out.delete();
            for (int k = 0; k < n; k++)
                add_step(chars[(n-1-k)*8 +: 8]);
        end
        for (int k = 0; k < step_out.size(); k++)
        begin
            r.out_byte     = step_out[k];
            r.run_last     = (k == step_out.size() - 1);
            r.message_done = last && r.run_last;
            add_result(r);
        end
    endtask

    // stop offering, wait out every awaited byte, then let held work settle
    task automatic drain();
        push <= 1'b0;
        while (encoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic keep, input logic [SAFE_W-1:0] mask);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_KEEP_ESCAPES;
        cfg_data  <= {17'h0, keep};
        @(posedge clk);
        cfg_index <= CFG_SAFE_MASK;
        cfg_data  <= mask;
        @(posedge clk);
        cfg_we    <= 1'b0;
        esc_keep  = keep;
        safe_bits = mask;
    endtask

    task automatic send_message();
        int unsigned len;
        int unsigned kind;
        logic [7:0]  b;
        msg_q.delete();
        if ($urandom_range(0, 7) == 0)
        begin
            // noise: raw bytes, message end at random
            len = $urandom_range(1, 8);
            repeat (len)
            begin
                b = 8'($urandom_range(0, 255));
                send_byte(b, $urandom_range(0, 3) == 0, 1'b0, 4'h0, '0);
            end
        end
        else
        begin
            len = $urandom_range(1, 10);
            repeat (len)
            begin
                kind = $urandom_range(0, 9);
                case (kind)
                    0, 1, 2: add_msg(HEX_POOL[$urandom_range(0, 21)*8 +: 8]);
                    3, 4:    add_msg(RESERVED[$urandom_range(0, SAFE_W-1)*8 +: 8]);
                    5:
                    begin
                        add_msg("%");
                        add_msg(HEX_POOL[$urandom_range(0, 21)*8 +: 8]);
                        add_msg(HEX_POOL[$urandom_range(0, 21)*8 +: 8]);
                    end
                    6:
                    begin
                        // broken escape
                        add_msg("%");
                        if ($urandom_range(0, 1))
                            add_msg(HEX_POOL[$urandom_range(0, 21)*8 +: 8]);
                        add_msg(8'($urandom_range(0, 255)));
                    end
                    default: add_msg(8'($urandom_range(0, 255)));
                endcase
            end
            foreach (msg_q[i])
                send_byte(msg_q[i], i == msg_q.size() - 1, 1'b0, 4'h0, '0);
        end
    endtask

    // result side: random pop gaps, one long hold on request
    initial
    begin
        int unsigned rx_wait;
        result_t     want;
        rx_wait = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (encoded_q.size() == 0)
                begin
                    $display("%0t: unexpected transfer: out_byte %h run_last %b message_done %b",
                             $time, out_byte, run_last, message_done);
                    fail_cnt++;
                end
                else
                begin
                    want = encoded_q.pop_front();
                    if (out_byte !== want.out_byte)
                    begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, want.out_byte, out_byte);
                        fail_cnt++;
                    end
                    if (run_last !== want.run_last)
                    begin
                        $display("%0t: run_last expected %b actual %b",
                                 $time, want.run_last, run_last);
                        fail_cnt++;
                    end
                    if (message_done !== want.message_done)
                    begin
                        $display("%0t: message_done expected %b actual %b",
                                 $time, want.message_done, message_done);
                        fail_cnt++;
                    end
                end
                rx_wait = rx_idle ? $urandom_range(0, 19) : 0;
            end
            if (rx_hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
                pop <= 1'b1;
            end
            else if (rx_wait > 0)
            begin
                pop <= 1'b0;
                rx_wait--;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("url_percent_encoder_core verification failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        logic              keep;
        logic [SAFE_W-1:0] mask;
        int                start_items;

        dir_rows = '{
            // reset config: no escapes kept, all reserved encoded
            known_row("A", 1'b0, 4'd1, "A"),
            known_row("z", 1'b0, 4'd1, "z"),
            known_row("0", 1'b0, 4'd1, "0"),
            known_row("~", 1'b0, 4'd1, "~"),
            known_row("-", 1'b1, 4'd1, "-"),
            known_row(8'h00, 1'b0, 4'd3, "%00"),
            known_row(8'hFF, 1'b0, 4'd3, "%FF"),
            known_row(":", 1'b0, 4'd3, "%3A"),
            known_row("%", 1'b1, 4'd3, "%25"),
            byte_row(" ", 1'b0),
            cfg_row(1'b1, 18'h3FFFF),
            known_row(":", 1'b0, 4'd1, ":"),
            known_row("=", 1'b0, 4'd1, "="),
            known_row("%", 1'b0, 4'd0, ""),
            known_row("4", 1'b0, 4'd0, ""),
            known_row("1", 1'b0, 4'd3, "%41"),
            known_row("%", 1'b0, 4'd0, ""),
            byte_row("g", 1'b0),
            byte_row("%", 1'b0),
            byte_row("a", 1'b0),
            byte_row("%", 1'b0),
            known_row("f", 1'b1, 4'd4, "%25f"),
            known_row("%", 1'b1, 4'd3, "%25"),
            byte_row("%", 1'b0),
            byte_row("B", 1'b0),
            known_row(8'h80, 1'b1, 4'd7, "%25B%80"),
            // escape left pending across a config change
            byte_row("%", 1'b0),
            cfg_row(1'b0, 18'h3FFFF),
            known_row("x", 1'b0, 4'd4, "%25x")
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                drain();
                write_regs(dir_rows[i].keep, dir_rows[i].value);
            end
            else
                send_byte(dir_rows[i].value[7:0], dir_rows[i].last, dir_rows[i].typed,
                          dir_rows[i].n, dir_rows[i].chars);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            case (p)
                0:       begin keep = 1'b1; mask = '0;        end
                1:       begin keep = 1'b0; mask = 18'h3FFFF; end
                3:       begin keep = 1'b1; mask = 18'h3FFFF; end
                4:       begin keep = 1'b0; mask = SAFE_W'($urandom_range(0, 18'h3FFFF)); end
                5:       begin keep = 1'b1; mask = 18'h1 << $urandom_range(0, SAFE_W-1); end
                7:
                begin
                    keep = 1'($urandom_range(0, 1));
                    mask = SAFE_W'($urandom_range(0, 18'h3FFFF));
                end
                default: begin keep = 1'b1; mask = SAFE_W'($urandom_range(0, 18'h3FFFF)); end
            endcase
            write_regs(keep, mask);
            tx_idle = !(p == 2 || p == 5);
            rx_idle = (p != 4);
            // receiver holds off while the sender streams back to back
            if (p == 2)
                rx_hold_req = 1'b1;
            start_items = items_sent;
            while (items_sent - start_items < PHASE_ITEMS)
            begin
                send_message();
                if (p == 6 && items_sent - start_items >= PHASE_ITEMS / 2 &&
                    items_sent - start_items < PHASE_ITEMS / 2 + 10)
                    drain();
            end
        end

        drain();
        if (fail_cnt == 0 && encoded_q.size() == 0)
            $display("url_percent_encoder_core verification clean");
        else
            $display("url_percent_encoder_core verification failed");
        $finish;
    end

endmodule
